/* hw/rtl/dds_pkg.sv */
package dds_pkg;

  // Table and channel sizing
  localparam int TABLE_DEPTH = 1024;
  localparam int CHANNELS    = 2;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Fixed field and register widths
  localparam int FRAC_W   = 8;            // fractional phase bits
  localparam int PHASE_W  = 18;
  localparam int SUM_W    = PHASE_W + 1;  // phase + step before wrap
  localparam int LEN_W    = 11;
  localparam int AMP_W    = 15;
  localparam int PWM_W    = 16;
  localparam int RATE_W   = 20;
  localparam int FREQ_W   = 16;
  localparam int SAMPLE_W = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Products and shared divider
  localparam int PROD_W = SAMPLE_W + PWM_W;       // widest product kept
  localparam int DIVD_W = LEN_W + FREQ_W + FRAC_W; // step dividend
  localparam int DIVS_W = RATE_W;
  localparam int ITER_W = $clog2(DIVD_W + 1);

  localparam logic [ITER_W-1:0] ITERS_DUTY = ITER_W'(PROD_W);
  localparam logic [ITER_W-1:0] ITERS_STEP = ITER_W'(DIVD_W);
  localparam logic [ITER_W-1:0] ITERS_WRAP = ITER_W'(SUM_W);

  // Reset values of the configuration registers
  localparam logic [LEN_W-1:0]  RST_TABLE_LENGTH = LEN_W'(1024);
  localparam logic [AMP_W-1:0]  RST_SINE_AMP     = AMP_W'(32767);
  localparam logic [PWM_W-1:0]  RST_PWM_PERIOD   = PWM_W'(1000);
  localparam logic [RATE_W-1:0] RST_SAMPLE_RATE  = RATE_W'(20000);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SETF  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_LENGTH = 2'd0,
    REG_SINE_AMP     = 2'd1,
    REG_PWM_PERIOD   = 2'd2,
    REG_SAMPLE_RATE  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_DUTY = 2'd0,
    DIV_STEP = 2'd1,
    DIV_WRAP = 2'd2
  } div_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_START_DUTY,
    ST_DIV_DUTY,
    ST_DIV_WRAP,
    ST_START_STEP,
    ST_DIV_STEP,
    ST_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    in_ready;
    logic    latch_in;
    logic    set_reject;
    logic    mem_wr;
    logic    mem_rd;
    logic    load_prod;
    logic    div_start;
    div_op_t div_op;
    logic    duty_wr;
    logic    step_wr;
    logic    phase_wr_sum;
    logic    phase_wr_rem;
    logic    res_ld;
  } dds_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_code_t cmd;
    logic      ch_ok;
    logic      freq_ok;
    logic      idx_ok;
    logic      need_wrap;
    logic      div_busy;
    logic      div_done;
    logic      out_free;
  } dds_sts_t;

endpackage

/* hw/rtl/dds_in_if.sv */
interface dds_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  channel;
  logic [15:0] frequency;
  logic [9:0]  table_index;
  logic [14:0] table_value;

  modport source (
    output valid, cmd, channel, frequency, table_index, table_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, channel, frequency, table_index, table_value,
    output ready
  );
endinterface

/* hw/rtl/dds_out_if.sv */
interface dds_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty;
  logic [1:0]  out_channel;
  logic        status;

  modport source (
    output valid, duty, out_channel, status,
    input  ready
  );
  modport sink (
    input  valid, duty, out_channel, status,
    output ready
  );
endinterface

/* hw/rtl/dds_sine_tone_generator_top.sv */
// Two-channel sine tone generator, table driven.
// in_if  : items with cmd (tick, set frequency, table write), channel, frequency,
//          table_index, table_value. Taken when valid and ready are both high.
// out_if : exactly one result item per input item: duty, out_channel, status.
// cfg_*  : write-only register port; cfg_index 0 table_length, 1 sine_amplitude,
//          2 pwm_period, 3 sample_rate. Write only while the block is idle.
// One item is worked at a time. Steps from accept to result loaded:
//   table write / rejected item   : decode, result
//   set frequency                 : decode, 35-bit step quotient, result
//   tick, no phase wrap           : decode, read, 31-bit duty quotient, result
//   tick, phase wrap              : as above plus a 19-bit remainder pass
// The shared restoring divider gives one quotient bit a cycle; a new item is
// taken the cycle after the previous result is loaded into the output register.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// both phases and phase steps; the wave table holds nothing until written.
// A stalled receiver holds the result in the output register; the block then
// finishes at most one further item and waits for the register to free up.
module dds_sine_tone_generator_top
  import dds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  dds_in_if.sink                in_if,
  dds_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dds_cmd_t ctl_cmd;
  dds_sts_t dp_sts;

  dds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .sts      (dp_sts),
    .cmd      (ctl_cmd)
  );

  dds_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (ctl_cmd),
    .sts            (dp_sts),
    .in_cmd         (in_if.cmd),
    .in_channel     (in_if.channel),
    .in_frequency   (in_if.frequency),
    .in_table_index (in_if.table_index),
    .in_table_value (in_if.table_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_ready      (out_if.ready),
    .out_valid      (out_if.valid),
    .out_duty       (out_if.duty),
    .out_channel    (out_if.out_channel),
    .out_status     (out_if.status)
  );

  assign in_if.ready = ctl_cmd.in_ready;

  // One item in flight: after an accept the input closes
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input accepted while an item is in flight");

  // Divider never restarted mid-division
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.div_start |-> !dp_sts.div_busy)
    else $error("divider started while busy");

  // Result only loaded when the output register is free
  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.res_ld |-> dp_sts.out_free)
    else $error("result overwrote a pending output");

  // Table is never read and written in the same cycle
  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl_cmd.mem_wr && ctl_cmd.mem_rd))
    else $error("wave table read and write together");

endmodule

/* hw/rtl/dds_div.sv */
// Restoring divider, one quotient bit a cycle.
// The dividend is left-aligned so that only the top iters bits are worked.
module dds_div
  import dds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  input  logic [ITER_W-1:0] iters,
  output logic [DIVD_W-1:0] quotient,
  output logic [DIVS_W-1:0] remainder,
  output logic              busy,
  output logic              done
);

  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DIVS_W:0]   trial;

  always_comb begin
    trial = {rem_r, quo_r[DIVD_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = DIVS_W'(trial - {1'b0, dvs_r});
      quo_nxt = {quo_r[DIVD_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DIVS_W-1:0];
      quo_nxt = {quo_r[DIVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign busy      = busy_r;
  assign done      = done_r;

endmodule

/* hw/rtl/dds_datapath.sv */
module dds_datapath
  import dds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dds_cmd_t              cmd,
  output dds_sts_t              sts,
  input  logic [1:0]            in_cmd,
  input  logic [1:0]            in_channel,
  input  logic [FREQ_W-1:0]     in_frequency,
  input  logic [9:0]            in_table_index,
  input  logic [SAMPLE_W-1:0]   in_table_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [PWM_W-1:0]      out_duty,
  output logic [1:0]            out_channel,
  output logic                  out_status
);

  // Configuration registers
  logic [LEN_W-1:0]  tlen_r;
  logic [AMP_W-1:0]  amp_r;
  logic [PWM_W-1:0]  pwm_r;
  logic [RATE_W-1:0] rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlen_r <= RST_TABLE_LENGTH;
      amp_r  <= RST_SINE_AMP;
      pwm_r  <= RST_PWM_PERIOD;
      rate_r <= RST_SAMPLE_RATE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TABLE_LENGTH: tlen_r <= cfg_wdata[LEN_W-1:0];
        REG_SINE_AMP:     amp_r  <= cfg_wdata[AMP_W-1:0];
        REG_PWM_PERIOD:   pwm_r  <= cfg_wdata[PWM_W-1:0];
        REG_SAMPLE_RATE:  rate_r <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Item registers
  logic [1:0]          cmd_r, ch_r;
  logic [FREQ_W-1:0]   freq_r;
  logic [9:0]          idx_r;
  logic [SAMPLE_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r  <= in_cmd;
      ch_r   <= in_channel;
      freq_r <= in_frequency;
      idx_r  <= in_table_index;
      val_r  <= in_table_value;
    end
  end

  // Active table length, clamped to 1..TABLE_DEPTH
  logic [LEN_W-1:0] len;
  logic [SUM_W-1:0] span;

  always_comb begin
    if (tlen_r == '0)
      len = LEN_W'(1);
    else if (tlen_r > LEN_W'(TABLE_DEPTH))
      len = LEN_W'(TABLE_DEPTH);
    else
      len = tlen_r;
  end

  assign span = SUM_W'({len, {FRAC_W{1'b0}}});

  // Channel state
  logic [PHASE_W-1:0] phase_r [CHANNELS];
  logic [PHASE_W-1:0] step_r  [CHANNELS];
  logic [CH_W-1:0]    ch_sel;
  logic [SUM_W-1:0]   sum_r;

  assign ch_sel = ch_r[CH_W-1:0];

  // Wave table
  logic [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr)
      wave_mem[idx_r[ADDR_W-1:0]] <= val_r;
    if (cmd.mem_rd)
      rd_data_r <= wave_mem[phase_r[ch_sel][FRAC_W +: ADDR_W]];
  end

  // Multiplier: sample * pwm_period for ticks, length * frequency otherwise
  logic [PWM_W-1:0]    mul_a, mul_b;
  logic [2*PWM_W-1:0]  mul_p;
  logic [PROD_W-1:0]   prod_r;

  always_comb begin
    if (cmd_code_t'(cmd_r) == CMD_TICK) begin
      mul_a = PWM_W'(rd_data_r);
      mul_b = pwm_r;
    end else begin
      mul_a = PWM_W'(len);
      mul_b = freq_r;
    end
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_prod) begin
      prod_r <= mul_p[PROD_W-1:0];
      sum_r  <= {1'b0, phase_r[ch_sel]} + {1'b0, step_r[ch_sel]};
    end
  end

  // Shared divider
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic [ITER_W-1:0] div_iters;
  logic [DIVD_W-1:0] div_quo;
  logic [DIVS_W-1:0] div_rem;
  logic              div_busy, div_done;

  always_comb begin
    unique case (cmd.div_op)
      DIV_STEP: begin
        div_dividend = {prod_r[LEN_W+FREQ_W-1:0], {FRAC_W{1'b0}}};
        div_divisor  = rate_r;
        div_iters    = ITERS_STEP;
      end
      DIV_WRAP: begin
        div_dividend = {sum_r, {(DIVD_W-SUM_W){1'b0}}};
        div_divisor  = DIVS_W'(span);
        div_iters    = ITERS_WRAP;
      end
      default: begin
        div_dividend = {prod_r, {(DIVD_W-PROD_W){1'b0}}};
        div_divisor  = DIVS_W'(amp_r);
        div_iters    = ITERS_DUTY;
      end
    endcase
  end

  dds_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .iters     (div_iters),
    .quotient  (div_quo),
    .remainder (div_rem),
    .busy      (div_busy),
    .done      (div_done)
  );

  // Duty with saturation; zero amplitude gives full period
  logic [PWM_W-1:0] duty_sat;

  always_comb begin
    if (amp_r == '0 || div_quo > DIVD_W'(pwm_r))
      duty_sat = pwm_r;
    else
      duty_sat = div_quo[PWM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_r[i] <= '0;
        step_r[i]  <= '0;
      end
    end else begin
      if (cmd.step_wr)
        step_r[ch_sel] <= div_quo[PHASE_W-1:0];
      if (cmd.phase_wr_sum)
        phase_r[ch_sel] <= sum_r[PHASE_W-1:0];
      else if (cmd.phase_wr_rem)
        phase_r[ch_sel] <= div_rem[PHASE_W-1:0];
    end
  end

  // Result being built
  logic [PWM_W-1:0] duty_r;
  logic             status_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      duty_r   <= '0;
      status_r <= 1'b0;
    end else begin
      if (cmd.set_reject)
        status_r <= 1'b1;
      if (cmd.duty_wr)
        duty_r <= duty_sat;
    end
  end

  // Output register
  logic             out_valid_r;
  logic [PWM_W-1:0] out_duty_r;
  logic [1:0]       out_ch_r;
  logic             out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (cmd.res_ld)
      out_valid_r <= 1'b1;
    else if (out_ready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      out_duty_r   <= duty_r;
      out_ch_r     <= ch_r;
      out_status_r <= status_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_duty    = out_duty_r;
  assign out_channel = out_ch_r;
  assign out_status  = out_status_r;

  // Status to the controller
  always_comb begin
    sts.cmd       = cmd_code_t'(cmd_r);
    sts.ch_ok     = 32'(ch_r) < CHANNELS;
    sts.freq_ok   = RATE_W'(freq_r) < (rate_r >> 1);
    sts.idx_ok    = 32'(idx_r) < TABLE_DEPTH;
    sts.need_wrap = sum_r >= span;
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.out_free  = !out_valid_r || out_ready;
  end

endmodule

/* hw/rtl/dds_ctrl.sv */
module dds_ctrl
  import dds_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dds_sts_t sts,
  output dds_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= ST_IDLE;
    else
      state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_op = DIV_DUTY;
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.cmd)
          CMD_TICK: begin
            if (sts.ch_ok) begin
              cmd.mem_rd = 1'b1;
              state_nxt  = ST_READ;
            end else begin
              cmd.set_reject = 1'b1;
              state_nxt      = ST_RESULT;
            end
          end
          CMD_SETF: begin
            if (sts.ch_ok && sts.freq_ok) begin
              cmd.load_prod = 1'b1;
              state_nxt     = ST_START_STEP;
            end else begin
              cmd.set_reject = 1'b1;
              state_nxt      = ST_RESULT;
            end
          end
          CMD_WRITE: begin
            if (sts.idx_ok)
              cmd.mem_wr = 1'b1;
            else
              cmd.set_reject = 1'b1;
            state_nxt = ST_RESULT;
          end
          CMD_NONE: begin
            cmd.set_reject = 1'b1;
            state_nxt      = ST_RESULT;
          end
        endcase
      end
      ST_READ: begin
        cmd.load_prod = 1'b1;
        state_nxt     = ST_START_DUTY;
      end
      ST_START_DUTY: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_DUTY;
        state_nxt     = ST_DIV_DUTY;
      end
      ST_DIV_DUTY: begin
        if (sts.div_done) begin
          cmd.duty_wr = 1'b1;
          if (sts.need_wrap) begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_WRAP;
            state_nxt     = ST_DIV_WRAP;
          end else begin
            cmd.phase_wr_sum = 1'b1;
            state_nxt        = ST_RESULT;
          end
        end
      end
      ST_DIV_WRAP: begin
        cmd.div_op = DIV_WRAP;
        if (sts.div_done) begin
          cmd.phase_wr_rem = 1'b1;
          state_nxt        = ST_RESULT;
        end
      end
      ST_START_STEP: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_STEP;
        state_nxt     = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd.div_op = DIV_STEP;
        if (sts.div_done) begin
          cmd.step_wr = 1'b1;
          state_nxt   = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.res_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
